// ===== design/yuv420_frame_psnr_defines.svh =====
// Assertion macros for the checker file of the frame PSNR block.
// No dependencies; included by bare file name.
`ifndef YUV420_FRAME_PSNR_DEFINES_SVH
`define YUV420_FRAME_PSNR_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define YFP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define YFP_ASSERT(label, prop, msg) \
    `YFP_ASSERT_CLK(label, i_clk, i_rst_n, prop, msg)

`endif

// ===== design/yfp_pkg.sv =====
// Types and constants of the YUV 4:2:0 frame PSNR block.
// No dependencies; imported by every module of the block.
package yfp_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int PLANE_W   = 2;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int PSNR_W    = 14;
    localparam int TOTAL_W   = 42;
    localparam int SUM_W     = 40;
    localparam int SQ_W      = 16;

    // log2 unit: input wide enough for 255^2 * N and for the total error
    localparam int LOG_IN_W = 43;
    localparam int LOG_FRAC = 24;
    localparam int EXP_W    = 6;
    localparam int LOG_W    = EXP_W + LOG_FRAC;
    localparam int MANT_W   = 32;
    localparam int K_W      = 32;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [K_W-1:0] TEN_LOG10_2_Q30 = 32'd3232284966;
    localparam logic [15:0]    PEAK_SQ         = 16'd65025;
    localparam int             PSNR_CAP_DB     = 60;

    localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_HEIGHT = 2'd3;

    localparam int RES_IDX_W = 2;
    localparam int RES_COUNT = 4;
    localparam logic [RES_IDX_W-1:0] RES_Y = 2'd0;
    localparam logic [RES_IDX_W-1:0] RES_U = 2'd1;
    localparam logic [RES_IDX_W-1:0] RES_V = 2'd2;
    localparam logic [RES_IDX_W-1:0] RES_F = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] source_sample;
        logic [SAMPLE_W-1:0] recon_sample;
        logic [PLANE_W-1:0]  plane;
        logic                frame_end;
    } t_in_item;

    typedef struct packed {
        logic [PSNR_W-1:0]  y_psnr;
        logic [PSNR_W-1:0]  u_psnr;
        logic [PSNR_W-1:0]  v_psnr;
        logic [PSNR_W-1:0]  frame_psnr;
        logic [TOTAL_W-1:0] total_sq_error;
    } t_out_item;

    typedef struct packed {
        logic [CFG_W-1:0] luma_width;
        logic [CFG_W-1:0] luma_height;
        logic [CFG_W-1:0] chroma_width;
        logic [CFG_W-1:0] chroma_height;
    } t_cfg;

    // per-frame error sums handed from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0] y_sse;
        logic [SUM_W-1:0] u_sse;
        logic [SUM_W-1:0] v_sse;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    typedef struct packed {
        logic                start;
        logic [LOG_IN_W-1:0] x;
    } t_log_req;

    typedef struct packed {
        logic             done;
        logic [LOG_W-1:0] value;
    } t_log_rsp;

endpackage

// ===== design/yuv420_frame_psnr.sv =====
// Per-frame PSNR of an 8-bit 4:2:0 picture against its reconstruction. The front
// end takes one source/reconstructed sample pair every cycle and stalls only when
// its two-entry job queue is full. Each frame end queues the three plane error
// sums; the back end then works out Y, U, V and frame PSNR in turn on one shared
// iterative log2 unit (up to 42 normalize shifts plus 24 squaring steps per log,
// two logs per value), and each frame's result appears in an output register that
// holds it until taken. Frames that arrive faster than the back end handles them
// back up into the queue and then stall the input.
// Depends on yfp_pkg, yfp_front, yfp_queue, yfp_log2, yfp_back.
module yuv420_frame_psnr #(
    parameter int MAX_WIDTH      = 4096,
    parameter int MAX_HEIGHT     = 4096,
    parameter int PSNR_FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  yfp_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output yfp_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [yfp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [yfp_pkg::CFG_W-1:0]       i_cfg_data
);
    import yfp_pkg::*;

    t_cfg      r_cfg;
    t_q_status w_q_status;
    t_job      w_push_job, w_head_job;
    logic      w_push, w_pop;
    t_log_req  w_log_req;
    t_log_rsp  w_log_rsp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.luma_width    <= CFG_W'(1);
            r_cfg.luma_height   <= CFG_W'(1);
            r_cfg.chroma_width  <= CFG_W'(1);
            r_cfg.chroma_height <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_LUMA_WIDTH:    r_cfg.luma_width    <= i_cfg_data;
                CFG_LUMA_HEIGHT:   r_cfg.luma_height   <= i_cfg_data;
                CFG_CHROMA_WIDTH:  r_cfg.chroma_width  <= i_cfg_data;
                CFG_CHROMA_HEIGHT: r_cfg.chroma_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    yfp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_job      (w_push_job)
    );

    yfp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_job    (w_push_job),
        .i_pop    (w_pop),
        .o_job    (w_head_job),
        .o_status (w_q_status)
    );

    yfp_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_log_req),
        .o_rsp   (w_log_rsp)
    );

    yfp_back #(
        .MAX_WIDTH      (MAX_WIDTH),
        .MAX_HEIGHT     (MAX_HEIGHT),
        .PSNR_FRAC_BITS (PSNR_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (w_q_status),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_log_req   (w_log_req),
        .i_log_rsp   (w_log_rsp),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== design/yfp_front.sv =====
// Front end: takes sample pairs, accumulates saturating squared error per plane,
// and pushes one job per frame into the queue. Depends on yfp_pkg.
module yfp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  yfp_pkg::t_in_item  i_in_data,
    input  yfp_pkg::t_q_status i_q_status,
    output logic               o_push,
    output yfp_pkg::t_job      o_job
);
    import yfp_pkg::*;

    logic [SUM_W-1:0]    r_y_sum, r_u_sum, r_v_sum;
    logic [SUM_W-1:0]    n_y_sum, n_u_sum, n_v_sum;
    logic [SAMPLE_W-1:0] w_diff;
    logic [SQ_W-1:0]     w_sq;
    logic                w_accept;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                input logic [SQ_W-1:0] a);
        logic [SUM_W:0] t;
        t = {1'b0, s} + (SUM_W + 1)'(a);
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    assign o_in_stall = i_q_status.full;
    assign w_accept   = i_in_valid && !i_q_status.full;

    always_comb begin
        w_diff = (i_in_data.source_sample >= i_in_data.recon_sample)
               ? i_in_data.source_sample - i_in_data.recon_sample
               : i_in_data.recon_sample - i_in_data.source_sample;
        w_sq = {8'd0, w_diff} * {8'd0, w_diff};

        n_y_sum = r_y_sum;
        n_u_sum = r_u_sum;
        n_v_sum = r_v_sum;
        if (w_accept) begin
            case (i_in_data.plane)
                PLANE_Y: n_y_sum = sat_add(r_y_sum, w_sq);
                PLANE_U: n_u_sum = sat_add(r_u_sum, w_sq);
                PLANE_V: n_v_sum = sat_add(r_v_sum, w_sq);
                default: ;  // unused tag: sample dropped
            endcase
        end
    end

    // the frame-end sample is already in the job
    assign o_push      = w_accept && i_in_data.frame_end;
    assign o_job.y_sse = n_y_sum;
    assign o_job.u_sse = n_u_sum;
    assign o_job.v_sse = n_v_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_y_sum <= '0;
            r_u_sum <= '0;
            r_v_sum <= '0;
        end else begin
            r_y_sum <= n_y_sum;
            r_u_sum <= n_u_sum;
            r_v_sum <= n_v_sum;
        end
    end

endmodule

// ===== design/yfp_queue.sv =====
// Short job queue between the accumulating front and the PSNR back end.
// Depends on yfp_pkg.
module yfp_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  yfp_pkg::t_job      i_job,
    input  logic               i_pop,
    output yfp_pkg::t_job      o_job,
    output yfp_pkg::t_q_status o_status
);
    import yfp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_job          = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop)      r_count <= r_count + CNT_W'(1);
            else if (i_pop && !i_push) r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

endmodule

// ===== design/yfp_log2.sv =====
// Iterative log2 in Q.24: one-bit-a-cycle normalization, then one squaring
// per fraction bit. Depends on yfp_pkg.
module yfp_log2 (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  yfp_pkg::t_log_req i_req,
    output yfp_pkg::t_log_rsp o_rsp
);
    import yfp_pkg::*;

    localparam int CNT_W = $clog2(LOG_FRAC);

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_FRAC = 3'b100
    } t_log_state;

    t_log_state          r_state;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [LOG_IN_W-1:0] r_x;
    logic [EXP_W-1:0]    r_exp;
    logic [MANT_W-1:0]   r_m;
    logic [LOG_FRAC-1:0] r_frac;
    logic [2*MANT_W-1:0] w_sq;

    assign w_sq        = r_m * r_m;
    assign o_rsp.done  = r_done;
    assign o_rsp.value = {r_exp, r_frac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                L_IDLE: begin
                    if (i_req.start) r_state <= L_NORM;
                end
                L_NORM: begin
                    if (r_x[LOG_IN_W-1]) begin
                        r_cnt   <= CNT_W'(LOG_FRAC - 1);
                        r_state <= L_FRAC;
                    end
                end
                L_FRAC: begin
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= L_IDLE;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                default: r_state <= L_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            L_IDLE: begin
                if (i_req.start) begin
                    r_x    <= i_req.x;
                    r_exp  <= EXP_W'(LOG_IN_W - 1);
                    r_frac <= '0;
                end
            end
            L_NORM: begin
                if (r_x[LOG_IN_W-1]) begin
                    // mantissa Q1.31, low bits truncated
                    r_m <= r_x[LOG_IN_W-1 -: MANT_W];
                end else begin
                    r_x   <= r_x << 1;
                    r_exp <= r_exp - EXP_W'(1);
                end
            end
            L_FRAC: begin
                r_frac <= {r_frac[LOG_FRAC-2:0], w_sq[2*MANT_W-1]};
                r_m    <= w_sq[2*MANT_W-1] ? w_sq[2*MANT_W-1 -: MANT_W]
                                           : w_sq[2*MANT_W-2 -: MANT_W];
            end
            default: ;
        endcase
    end

endmodule

// ===== design/yfp_back.sv =====
// Back end: pops frame jobs, computes four PSNR values with the shared log2
// unit and holds the result in the output register. Depends on yfp_pkg.
module yfp_back #(
    parameter int MAX_WIDTH      = 4096,
    parameter int MAX_HEIGHT     = 4096,
    parameter int PSNR_FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  yfp_pkg::t_cfg      i_cfg,
    input  yfp_pkg::t_q_status i_q_status,
    input  yfp_pkg::t_job      i_job,
    output logic               o_pop,
    output yfp_pkg::t_log_req  o_log_req,
    input  yfp_pkg::t_log_rsp  i_log_rsp,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output yfp_pkg::t_out_item o_out_data
);
    import yfp_pkg::*;

    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int W_DIM_W = (MAX_WIDTH > CFG_MAX) ? CFG_W : $clog2(MAX_WIDTH + 1);
    localparam int H_DIM_W = (MAX_HEIGHT > CFG_MAX) ? CFG_W : $clog2(MAX_HEIGHT + 1);
    localparam int NY_W    = W_DIM_W + H_DIM_W;
    localparam int NF_W    = NY_W + 1;
    localparam int NUM_W   = NF_W + 16;
    localparam int PROD_W  = LOG_W + K_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int RND_SH  = 54 - PSNR_FRAC_BITS;
    localparam int P_W     = ACC_W - RND_SH;
    localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (53 - PSNR_FRAC_BITS);
    localparam logic [P_W-1:0]   CAP = P_W'(PSNR_CAP_DB) << PSNR_FRAC_BITS;
    localparam logic [PSNR_W-1:0] CAP_OUT = PSNR_W'(CAP);

    typedef enum logic [9:0] {
        B_IDLE = 10'b00_0000_0001,
        B_DIM  = 10'b00_0000_0010,
        B_NF   = 10'b00_0000_0100,
        B_NUM  = 10'b00_0000_1000,
        B_CHK  = 10'b00_0001_0000,
        B_LOGN = 10'b00_0010_0000,
        B_LOGD = 10'b00_0100_0000,
        B_MUL  = 10'b00_1000_0000,
        B_RND  = 10'b01_0000_0000,
        B_OUT  = 10'b10_0000_0000
    } t_back_state;

    t_back_state          r_state;
    t_back_state          w_adv_state;
    logic [RES_IDX_W-1:0] r_k;
    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic [SUM_W-1:0]   r_sse_y, r_sse_u, r_sse_v;
    logic [TOTAL_W-1:0] r_tot, r_sse_cur, w_sse_sel;
    logic [NY_W-1:0]    r_ny, r_nc;
    logic [NF_W-1:0]    r_nf, w_n_sel;
    logic [NY_W+1:0]    w_ny3;
    logic [NUM_W-1:0]   r_num;
    logic [LOG_W-1:0]   r_ln, r_diff;
    logic [PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]   w_acc;
    logic [P_W-1:0]     w_p, w_p_cap;
    logic [PSNR_W-1:0]  r_res [RES_COUNT];

    logic              w_out_free, w_chk_direct, w_no_gain, w_res_we;
    logic [PSNR_W-1:0] w_res_val;

    function automatic logic [W_DIM_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
        return (32'(v) > 32'(MAX_WIDTH)) ? W_DIM_W'(MAX_WIDTH) : W_DIM_W'(v);
    endfunction

    function automatic logic [H_DIM_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
        return (32'(v) > 32'(MAX_HEIGHT)) ? H_DIM_W'(MAX_HEIGHT) : H_DIM_W'(v);
    endfunction

    assign o_out_valid  = r_out_valid;
    assign o_out_data   = r_out_data;
    assign o_pop        = (r_state == B_IDLE) && !i_q_status.empty;
    assign w_out_free   = !r_out_valid || !i_out_stall;
    assign w_chk_direct = (r_sse_cur == '0) || (r_num == '0);
    assign w_no_gain    = (r_ln <= i_log_rsp.value);
    assign w_adv_state  = (r_k == RES_F) ? B_OUT : B_NUM;
    assign w_ny3        = {1'b0, r_ny, 1'b0} + (NY_W + 2)'(r_ny);
    assign w_acc        = ACC_W'(r_prod) + RND;
    assign w_p          = w_acc[ACC_W-1:RND_SH];
    assign w_p_cap      = (w_p > CAP) ? CAP : w_p;

    always_comb begin
        case (r_k)
            RES_Y:        w_n_sel = NF_W'(r_ny);
            RES_U, RES_V: w_n_sel = NF_W'(r_nc);
            default:      w_n_sel = r_nf;
        endcase
        case (r_k)
            RES_Y:   w_sse_sel = TOTAL_W'(r_sse_y);
            RES_U:   w_sse_sel = TOTAL_W'(r_sse_u);
            RES_V:   w_sse_sel = TOTAL_W'(r_sse_v);
            default: w_sse_sel = r_tot;
        endcase
    end

    always_comb begin
        o_log_req.start = 1'b0;
        o_log_req.x     = LOG_IN_W'(r_num);
        w_res_we        = 1'b0;
        w_res_val       = '0;
        case (r_state)
            B_CHK: begin
                if (w_chk_direct) begin
                    // no error: full cap; no samples but some error: zero
                    w_res_we  = 1'b1;
                    w_res_val = (r_sse_cur == '0) ? CAP_OUT : '0;
                end else begin
                    o_log_req.start = 1'b1;
                end
            end
            B_LOGN: begin
                if (i_log_rsp.done) begin
                    o_log_req.start = 1'b1;
                    o_log_req.x     = LOG_IN_W'(r_sse_cur);
                end
            end
            B_LOGD: begin
                if (i_log_rsp.done && w_no_gain) w_res_we = 1'b1;
            end
            B_RND: begin
                w_res_we  = 1'b1;
                w_res_val = PSNR_W'(w_p_cap);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_k         <= RES_Y;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                B_IDLE: if (!i_q_status.empty) r_state <= B_DIM;
                B_DIM: begin
                    r_k     <= RES_Y;
                    r_state <= B_NF;
                end
                B_NF:  r_state <= B_NUM;
                B_NUM: r_state <= B_CHK;
                B_CHK: begin
                    if (w_chk_direct) begin
                        r_k     <= r_k + RES_IDX_W'(1);
                        r_state <= w_adv_state;
                    end else begin
                        r_state <= B_LOGN;
                    end
                end
                B_LOGN: if (i_log_rsp.done) r_state <= B_LOGD;
                B_LOGD: begin
                    if (i_log_rsp.done) begin
                        if (w_no_gain) begin
                            r_k     <= r_k + RES_IDX_W'(1);
                            r_state <= w_adv_state;
                        end else begin
                            r_state <= B_MUL;
                        end
                    end
                end
                B_MUL: r_state <= B_RND;
                B_RND: begin
                    r_k     <= r_k + RES_IDX_W'(1);
                    r_state <= w_adv_state;
                end
                B_OUT: if (w_out_free) r_state <= B_IDLE;
                default: r_state <= B_IDLE;
            endcase

            if (r_state == B_OUT && w_out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall)              r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    r_sse_y <= i_job.y_sse;
                    r_sse_u <= i_job.u_sse;
                    r_sse_v <= i_job.v_sse;
                end
            end
            B_DIM: begin
                r_ny  <= clamp_w(i_cfg.luma_width) * clamp_h(i_cfg.luma_height);
                r_nc  <= clamp_w(i_cfg.chroma_width) * clamp_h(i_cfg.chroma_height);
                r_tot <= TOTAL_W'(r_sse_y) + TOTAL_W'(r_sse_u) + TOTAL_W'(r_sse_v);
            end
            B_NF:  r_nf <= w_ny3[NY_W+1:1];  // luma count * 3 / 2
            B_NUM: begin
                r_num     <= w_n_sel * PEAK_SQ;
                r_sse_cur <= w_sse_sel;
            end
            B_LOGN: if (i_log_rsp.done) r_ln <= i_log_rsp.value;
            B_LOGD: if (i_log_rsp.done && !w_no_gain) r_diff <= r_ln - i_log_rsp.value;
            B_MUL:  r_prod <= r_diff * TEN_LOG10_2_Q30;
            B_OUT: begin
                if (w_out_free) begin
                    r_out_data.y_psnr         <= r_res[RES_Y];
                    r_out_data.u_psnr         <= r_res[RES_U];
                    r_out_data.v_psnr         <= r_res[RES_V];
                    r_out_data.frame_psnr     <= r_res[RES_F];
                    r_out_data.total_sq_error <= r_tot;
                end
            end
            default: ;
        endcase

        if (w_res_we) r_res[r_k] <= w_res_val;
    end

endmodule

// ===== design/yfp_checker.sv =====
// Port-level checks of the frame PSNR block, bound to the top level.
// Depends on yfp_pkg and yuv420_frame_psnr_defines.svh.
`include "yuv420_frame_psnr_defines.svh"

module yfp_checker #(
    parameter int PSNR_FRAC_BITS = 8
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input yfp_pkg::t_in_item             i_in_data,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input yfp_pkg::t_out_item            o_out_data,
    input logic                          i_cfg_valid,
    input logic                          o_cfg_ready,
    input logic [yfp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [yfp_pkg::CFG_W-1:0]     i_cfg_data
);
    import yfp_pkg::*;

    localparam logic [PSNR_W-1:0] CAP_OUT = PSNR_W'(PSNR_CAP_DB << PSNR_FRAC_BITS);
    localparam logic              CAP_FITS = (PSNR_FRAC_BITS <= 8);

    logic w_out_hold, w_zero_err, w_none_over, w_all_capped;

    assign w_out_hold   = o_out_valid && i_out_stall;
    assign w_zero_err   = (o_out_data.total_sq_error == '0);
    assign w_none_over  = (o_out_data.y_psnr <= CAP_OUT) && (o_out_data.u_psnr <= CAP_OUT)
                       && (o_out_data.v_psnr <= CAP_OUT) && (o_out_data.frame_psnr <= CAP_OUT);
    assign w_all_capped = (o_out_data.y_psnr == CAP_OUT) && (o_out_data.u_psnr == CAP_OUT)
                       && (o_out_data.v_psnr == CAP_OUT) && (o_out_data.frame_psnr == CAP_OUT);

    // a stalled result transaction stays up and unchanged
    `YFP_ASSERT(a_out_valid_held, w_out_hold |=> o_out_valid, "result dropped while stalled")
    `YFP_ASSERT(a_out_data_held, w_out_hold |=> $stable(o_out_data), "result changed while stalled")

    // no PSNR above the 60 dB cap (checked only while PSNR_FRAC_BITS is at most 8)
    `YFP_ASSERT(a_psnr_capped, (o_out_valid && CAP_FITS) |-> w_none_over, "PSNR above cap")

    // an error-free frame reports the cap on every plane
    `YFP_ASSERT(a_zero_error_cap, (o_out_valid && w_zero_err) |-> w_all_capped, "zero error, no cap")

endmodule

bind yuv420_frame_psnr yfp_checker #(
    .PSNR_FRAC_BITS (PSNR_FRAC_BITS)
) u_yfp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data),
    .i_cfg_valid (i_cfg_valid),
    .o_cfg_ready (o_cfg_ready),
    .i_cfg_index (i_cfg_index),
    .i_cfg_data  (i_cfg_data)
);

// ===== tb/yuv420_frame_psnr_test.sv =====
// Self-checking bench for yuv420_frame_psnr: streams tagged sample pairs under random
// idling, predicts each frame's plane PSNRs and total error in fixed point, and checks them.
// Depends on yfp_pkg and the yuv420_frame_psnr RTL.
`timescale 1ns / 100ps

module yuv420_frame_psnr_test;
    import yfp_pkg::*;

    localparam int FRAC_BITS     = 8;
    localparam int DIM_LIMIT     = 4096;
    localparam int SETTLE_CYCLES = 600;     // worst-case back-end time for one frame
    localparam int RANDOM_ITEMS  = 1900;
    localparam int N_PHASES      = 6;
    localparam int DIR_ROWS      = 14;

    localparam logic [63:0]          SSE_MAX    = (64'd1 << SUM_W) - 64'd1;
    localparam logic [PSNR_W-1:0]    PSNR_CAP   = PSNR_W'(PSNR_CAP_DB << FRAC_BITS);
    localparam logic [PSNR_W-1:0]    PSNR_ZERO  = '0;
    localparam logic [PLANE_W-1:0]   PLANE_NONE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ORDER [4] =
        '{CFG_LUMA_WIDTH, CFG_LUMA_HEIGHT, CFG_CHROMA_WIDTH, CFG_CHROMA_HEIGHT};

    localparam t_out_item ALL_CAP = '{PSNR_CAP, PSNR_CAP, PSNR_CAP, PSNR_CAP, '0};
    localparam t_out_item FULL_SCALE_ERR =
        '{PSNR_ZERO, PSNR_ZERO, PSNR_ZERO, PSNR_ZERO, 42'd195075};

    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item result;
    } t_dir_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_LUMA_WIDTH;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // predictor copy of the registers and the per-plane error sums
    logic [CFG_W-1:0] luma_w = 1, luma_h = 1, chroma_w = 1, chroma_h = 1;
    logic [63:0]      y_sse = '0, u_sse = '0, v_sse = '0;

    t_out_item expected_frames [$];
    int failures = 0, results_seen = 0, items_sent = 0, counted_items = 0;
    int in_idle_pct = 21, out_stall_pct = 87;

    yuv420_frame_psnr #(
        .MAX_WIDTH      (DIM_LIMIT),
        .MAX_HEIGHT     (DIM_LIMIT),
        .PSNR_FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // log2 in Q.24: top-bit index, then fraction bits by repeated squaring of a Q1.31 mantissa
    function automatic logic [63:0] fixed_log2(input logic [63:0] x);
        int unsigned msb = 0;
        logic [63:0] mant, sq;
        logic [LOG_FRAC-1:0] frac;
        for (int b = 0; b < 64; b++) if (x[b]) msb = b;
        mant = (msb <= 31) ? x << (31 - msb) : x >> (msb - 31);
        for (int i = LOG_FRAC - 1; i >= 0; i--) begin
            sq = mant * mant;
            frac[i] = sq[63];
            mant = sq[63] ? sq >> 32 : sq >> 31;
        end
        return (64'(msb) << LOG_FRAC) | 64'(frac);
    endfunction

    function automatic logic [PSNR_W-1:0] psnr_db_q8(input logic [63:0] count,
                                                     input logic [63:0] sse);
        logic [63:0] cap, num, ln, ld, p;
        cap = 64'(PSNR_CAP_DB) << FRAC_BITS;
        if (sse == 0) return cap[PSNR_W-1:0];
        num = count * PEAK_SQ;
        if (num == 0) return PSNR_ZERO;
        ln = fixed_log2(num);
        ld = fixed_log2(sse);
        if (ln <= ld) return PSNR_ZERO;
        p = ((ln - ld) * TEN_LOG10_2_Q30 + (64'd1 << (53 - FRAC_BITS))) >> (54 - FRAC_BITS);
        if (p > cap) p = cap;
        return p[PSNR_W-1:0];
    endfunction

    function automatic logic [63:0] sample_count(input logic [CFG_W-1:0] w,
                                                 input logic [CFG_W-1:0] h);
        logic [63:0] cw, ch;
        cw = (w > DIM_LIMIT) ? 64'(DIM_LIMIT) : 64'(w);
        ch = (h > DIM_LIMIT) ? 64'(DIM_LIMIT) : 64'(h);
        return cw * ch;
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] sum, input logic [63:0] sq);
        return (sum + sq > SSE_MAX) ? SSE_MAX : sum + sq;
    endfunction

    // accumulate one sample pair; on frame end produce the frame result and clear the sums
    function automatic bit frame_step(input t_in_item it, output t_out_item res);
        logic [63:0] sq, total, ny, nc;
        sq = (it.source_sample >= it.recon_sample) ? it.source_sample - it.recon_sample
                                                   : it.recon_sample - it.source_sample;
        sq = sq * sq;
        case (it.plane)
            PLANE_Y: y_sse = add_sat(y_sse, sq);
            PLANE_U: u_sse = add_sat(u_sse, sq);
            PLANE_V: v_sse = add_sat(v_sse, sq);
            default: ;
        endcase
        res = '0;
        if (!it.frame_end) return 1'b0;
        ny    = sample_count(luma_w, luma_h);
        nc    = sample_count(chroma_w, chroma_h);
        total = y_sse + u_sse + v_sse;
        res.y_psnr         = psnr_db_q8(ny, y_sse);
        res.u_psnr         = psnr_db_q8(nc, u_sse);
        res.v_psnr         = psnr_db_q8(nc, v_sse);
        res.frame_psnr     = psnr_db_q8(ny * 3 / 2, total);
        res.total_sq_error = total[TOTAL_W-1:0];
        y_sse = '0;
        u_sse = '0;
        v_sse = '0;
        return 1'b1;
    endfunction

    function automatic t_in_item make_sample(input logic [PLANE_W-1:0] plane, input bit last);
        t_in_item it;
        int r;
        it.source_sample = SAMPLE_W'($urandom_range(255));
        r = int'(it.source_sample);
        case ($urandom_range(9))
            0, 1, 2, 3: r = r + int'($urandom_range(4)) - 2;
            4, 5: ;
            default: r = int'($urandom_range(255));
        endcase
        if (r < 0) r = 0;
        if (r > 255) r = 255;
        it.recon_sample = SAMPLE_W'(r);
        it.plane        = plane;
        it.frame_end    = last;
        return it;
    endfunction

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (it.plane != PLANE_NONE || it.frame_end) counted_items++;
        if (frame_step(it, res)) expected_frames.push_back(typed ? typed_res : res);
    endtask

    task automatic write_config(input logic [CFG_W-1:0] lw, input logic [CFG_W-1:0] lh,
                                input logic [CFG_W-1:0] cw, input logic [CFG_W-1:0] ch);
        logic [CFG_W-1:0] vals [4];
        vals = '{lw, lh, cw, ch};
        for (int k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REG_ORDER[k];
            i_cfg_data  <= vals[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (REG_ORDER[k])
                CFG_LUMA_WIDTH:    luma_w   = vals[k];
                CFG_LUMA_HEIGHT:   luma_h   = vals[k];
                CFG_CHROMA_WIDTH:  chroma_w = vals[k];
                CFG_CHROMA_HEIGHT: chroma_h = vals[k];
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
    endtask

    // hold the input off until every pending frame has come out, then let the back end settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < out_stall_pct);

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_frames.size() == 0) begin
                $error("frame result transaction with no frame end pending");
                failures++;
            end else begin
                want = expected_frames.pop_front();
                check_field("y_psnr", want.y_psnr, o_out_data.y_psnr);
                check_field("u_psnr", want.u_psnr, o_out_data.u_psnr);
                check_field("v_psnr", want.v_psnr, o_out_data.v_psnr);
                check_field("frame_psnr", want.frame_psnr, o_out_data.frame_psnr);
                check_field("total_sq_error", want.total_sq_error, o_out_data.total_sq_error);
            end
        end
    end

    initial begin
        t_dir_row         dir_rows [DIR_ROWS];
        logic [CFG_W-1:0] phase_cfg [N_PHASES][4];
        logic [PLANE_W-1:0] pl;
        int len_y, len_c, len_all, cut, kind, target;

        // reset registers: one sample per plane, frame count rounds down to one
        dir_rows = '{
            '{'{8'h00, 8'h00, PLANE_Y,    1'b1}, 1'b1, ALL_CAP},
            '{'{8'hFF, 8'h00, PLANE_Y,    1'b0}, 1'b0, '0},
            '{'{8'h00, 8'hFF, PLANE_U,    1'b0}, 1'b0, '0},
            '{'{8'hFF, 8'h00, PLANE_V,    1'b1}, 1'b1, FULL_SCALE_ERR},
            '{'{8'hFF, 8'h00, PLANE_NONE, 1'b1}, 1'b1, ALL_CAP},
            '{'{8'hAA, 8'h55, PLANE_Y,    1'b0}, 1'b0, '0},
            '{'{8'h55, 8'hAA, PLANE_U,    1'b0}, 1'b0, '0},
            '{'{8'h01, 8'h00, PLANE_V,    1'b1}, 1'b0, '0},
            '{'{8'h80, 8'h7F, PLANE_Y,    1'b1}, 1'b0, '0},
            '{'{8'h00, 8'h00, PLANE_U,    1'b0}, 1'b0, '0},
            '{'{8'h7F, 8'h80, PLANE_U,    1'b1}, 1'b0, '0},
            '{'{8'hFF, 8'hFF, PLANE_V,    1'b0}, 1'b0, '0},
            '{'{8'h00, 8'hFF, PLANE_NONE, 1'b0}, 1'b0, '0},
            '{'{8'h10, 8'h20, PLANE_V,    1'b1}, 1'b0, '0}
        };
        // small size, zero and over-range sizes, full size, near-cap size, random small, odd mix
        phase_cfg = '{
            '{13'd4,    13'd4,    13'd2,    13'd2},
            '{13'd0,    13'd3,    13'd8191, 13'd0},
            '{13'd8191, 13'd8191, 13'd8191, 13'd8191},
            '{13'd64,   13'd64,   13'd32,   13'd32},
            '{13'd1,    13'd1,    13'd1,    13'd1},
            '{13'd1,    13'd4096, 13'd1,    13'd2048}
        };
        phase_cfg[4][0] = CFG_W'($urandom_range(1, 16));
        phase_cfg[4][1] = CFG_W'($urandom_range(1, 16));
        phase_cfg[4][2] = CFG_W'($urandom_range(1, 8));
        phase_cfg[4][3] = CFG_W'($urandom_range(1, 8));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].result);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            wait_idle();
            in_idle_pct   = (ph < 2) ? 21 : (ph < 4) ? 87 : 0;
            out_stall_pct = (ph < 2) ? 87 : (ph < 4) ? 21 : 0;
            write_config(phase_cfg[ph][0], phase_cfg[ph][1], phase_cfg[ph][2], phase_cfg[ph][3]);
            target = counted_items + RANDOM_ITEMS / N_PHASES;
            while (counted_items < target) begin
                // real frame sizes when small, otherwise short frames of random length
                len_y = int'(sample_count(luma_w, luma_h));
                if (len_y == 0 || len_y > 48) len_y = $urandom_range(1, 16);
                len_c = int'(sample_count(chroma_w, chroma_h));
                if (len_c == 0 || len_c > 24) len_c = $urandom_range(1, 8);
                len_all = len_y + 2 * len_c;
                kind = $urandom_range(9);
                if (kind == 9) begin
                    repeat ($urandom_range(1, 6))
                        send_item(make_sample(PLANE_W'($urandom_range(3)),
                                              $urandom_range(7) == 0), 1'b0, '0);
                end else begin
                    cut = (kind == 8) ? $urandom_range(1, len_all) : len_all;
                    for (int k = 0; k < cut; k++) begin
                        pl = (k < len_y) ? PLANE_Y : (k < len_y + len_c) ? PLANE_U : PLANE_V;
                        send_item(make_sample(pl, k == cut - 1), 1'b0, '0);
                    end
                end
            end
        end
        wait_idle();

        $display("Run covered %0d sample transactions and %0d frame results", items_sent,
                 results_seen);
        $display("over %0d register settings (zero, over-range, full and small sizes)",
                 N_PHASES + 1);
        if (failures == 0 && expected_frames.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #120_000_000;
        $error("timeout with %0d frame results outstanding", expected_frames.size());
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/yfp_pkg.sv
design/yfp_front.sv
design/yfp_queue.sv
design/yfp_log2.sv
design/yfp_back.sv
design/yuv420_frame_psnr.sv
design/yfp_checker.sv
tb/yuv420_frame_psnr_test.sv
